// ===== design/alert_rule_state_machine_top_defines.svh =====
// assertion macros shared by the alert rule state machine modules
`ifndef ALERT_RULE_STATE_MACHINE_TOP_DEFINES_SVH
`define ALERT_RULE_STATE_MACHINE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ARSM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ARSM_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ARSM_ASSERT(name, prop, msg)
`define ARSM_ASSERT_RST(name, prop, msg)
`endif

`endif

// ===== design/arsm_pkg.sv =====
// types, codes and constants of the alert rule state machine
package arsm_pkg;

  localparam int unsigned DEVICES_DEF   = 16;
  localparam int unsigned TIME_BITS_DEF = 48;
  localparam int unsigned DEV_FIELD_W   = 4;
  localparam int unsigned PEAK_W        = 32;
  localparam int unsigned CFG_W         = 32;
  localparam int unsigned DUR_W         = CFG_W + 1;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE    = 2'd2;

  typedef enum logic [2:0] {
    M_NORMAL     = 3'd0,
    M_PENDING    = 3'd1,
    M_FIRING     = 3'd2,
    M_RECOVERING = 3'd3,
    M_COOLDOWN   = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    EV_TO_NORMAL      = 4'd0,
    EV_PENDING        = 4'd1,
    EV_FIRE_NEW       = 4'd2,
    EV_FIRE_REOPEN    = 4'd3,
    EV_HIT            = 4'd4,
    EV_BACK_FIRING    = 4'd5,
    EV_RECOVERING     = 4'd6,
    EV_CLOSE_NORMAL   = 4'd7,
    EV_CLOSE_COOLDOWN = 4'd8
  } event_code_e;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'd0,
    S_IDLE   = 3'd1,
    S_CMP1   = 3'd2,
    S_CMP2   = 3'd3,
    S_COMMIT = 3'd4
  } seq_state_e;

  typedef struct packed {
    logic [DEV_FIELD_W-1:0]   device;
    event_code_e              code;
    mode_e                    mode;
    logic signed [PEAK_W-1:0] peak;
    logic                     last;
  } event_t;

endpackage

// ===== design/arsm_elapsed.sv =====
// shared interval unit: has at least dur passed from ref to now
module arsm_elapsed import arsm_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [TIME_BITS-1:0] ref_i,
  input  logic [DUR_W-1:0]     dur_i,
  output logic                 elapsed_o
);

  localparam int unsigned CW = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

  logic [TIME_BITS:0] diff;

  // borrow out means time went backwards: not yet elapsed
  assign diff      = {1'b0, now_i} - {1'b0, ref_i};
  assign elapsed_o = !diff[TIME_BITS] && (CW'(diff[TIME_BITS-1:0]) >= CW'(dur_i));

endmodule

// ===== design/arsm_evq.sv =====
// two-entry event buffer between the sequencer and the output channel
`include "alert_rule_state_machine_top_defines.svh"
module arsm_evq import arsm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic [1:0]               n_i,
  input  event_t [1:0]             ev_i,
  output logic                     empty_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [DEV_FIELD_W-1:0]   event_device_o,
  output logic [3:0]               event_code_o,
  output logic [2:0]               new_mode_o,
  output logic signed [PEAK_W-1:0] event_peak_o,
  output logic                     last_event_o
);

  logic [1:0]   cnt_q, cnt_d;
  event_t [1:0] slot_q;
  logic         pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign empty_o     = (cnt_q == 2'd0);
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = n_i;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= ev_i;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
    end
  end

  assign event_device_o = slot_q[0].device;
  assign event_code_o   = slot_q[0].code;
  assign new_mode_o     = slot_q[0].mode;
  assign event_peak_o   = slot_q[0].peak;
  assign last_event_o   = slot_q[0].last;

  `ARSM_ASSERT(a_load_empty, load_i |-> cnt_q == 2'd0, "event buffer loaded while not empty")
  `ARSM_ASSERT(a_cnt_range, cnt_q != 2'd3, "event buffer count out of range")
  `ARSM_ASSERT(a_last_tail, out_valid_o && slot_q[0].last |-> cnt_q == 2'd1, "last event not at tail")
  `ARSM_ASSERT(a_load_cnt, load_i |=> cnt_q == $past(n_i), "event count not taken on load")

endmodule

// ===== design/alert_rule_state_machine_top.sv =====
// alert rule state machine: per-device five-state alert tracking with event records
// events of an accepted item are offered once its commit has loaded them into the event buffer
// an acting item needs one state read, two passes of the shared interval unit and one
//   commit, and no new item is taken until it is back in idle; ignored items do not stall
// a commit waits while the previous item's events are still buffered
// reset: asynchronous; then a clearing pass that writes every entry of the state memory
`include "alert_rule_state_machine_top_defines.svh"
module alert_rule_state_machine_top import arsm_pkg::*; #(
  parameter int unsigned DEVICES   = DEVICES_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [DEV_FIELD_W-1:0]   device_i,
  input  logic [TIME_BITS-1:0]     eval_time_i,
  input  logic                     eval_valid_i,
  input  logic                     data_present_i,
  input  logic                     condition_met_i,
  input  logic                     recovery_met_i,
  input  logic signed [PEAK_W-1:0] peak_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [DEV_FIELD_W-1:0]   event_device_o,
  output logic [3:0]               event_code_o,
  output logic [2:0]               new_mode_o,
  output logic signed [PEAK_W-1:0] event_peak_o,
  output logic                     last_event_o
);

  localparam int unsigned DEV_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

  typedef struct packed {
    mode_e                mode;
    logic [TIME_BITS-1:0] since;
    logic [TIME_BITS-1:0] close;
    logic                 has_inc;
  } entry_t;

  // configuration
  logic [CFG_W-1:0] sustain_q, cooldown_q, merge_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sustain_q  <= '0;
      cooldown_q <= '0;
      merge_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SUSTAIN:  sustain_q  <= cfg_data_i;
        CFG_COOLDOWN: cooldown_q <= cfg_data_i;
        CFG_MERGE:    merge_q    <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // sequencer
  seq_state_e state_q, state_d;
  logic [DEV_W-1:0] clr_q;
  logic             clr_last;
  logic             in_acc, in_range, go;
  logic [DEV_W-1:0] in_idx;
  logic             q_empty, q_load;

  assign in_range = 32'(device_i) < DEVICES;
  assign in_idx   = DEV_W'(device_i);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign go       = in_acc && eval_valid_i && in_range;
  assign clr_last = (clr_q == DEV_W'(DEVICES - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (clr_last) state_d = S_IDLE;
      S_IDLE:   if (go) state_d = S_CMP1;
      S_CMP1:   state_d = S_CMP2;
      S_CMP2:   state_d = S_COMMIT;
      S_COMMIT: if (q_empty) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // item registers
  logic [DEV_W-1:0]         idx_q;
  logic [DEV_FIELD_W-1:0]   dev_q;
  logic [TIME_BITS-1:0]     now_q;
  logic                     hd_q, cm_q, rm_q;
  logic signed [PEAK_W-1:0] peak_q;

  always_ff @(posedge clk_i) begin
    if (go) begin
      idx_q  <= in_idx;
      dev_q  <= device_i;
      now_q  <= eval_time_i;
      hd_q   <= data_present_i;
      cm_q   <= condition_met_i;
      rm_q   <= recovery_met_i;
      peak_q <= peak_sample_i;
    end
  end

  // state memory
  entry_t           mem [DEVICES];
  entry_t           rd_q;
  entry_t           mem_wd, dec_entry, clr_entry;
  logic             mem_we;
  logic [DEV_W-1:0] mem_wa;
  logic [1:0]       dec_n;

  assign clr_entry = '{mode: M_NORMAL, since: '0, close: '0, has_inc: 1'b0};

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    mem_we     = 1'b0;
    mem_wa     = idx_q;
    mem_wd     = dec_entry;
    q_load     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = clr_entry;
      end
      S_COMMIT: begin
        mem_we = q_empty;
        q_load = q_empty && (dec_n != 2'd0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (go) begin
      rd_q <= mem[in_idx];
    end
  end

  // shared interval unit: cooldown or sustain from since, then merge window from close
  logic [TIME_BITS-1:0] unit_ref;
  logic [DUR_W-1:0]     unit_dur;
  logic                 unit_out;
  logic                 e1_q, e2_q;

  always_comb begin
    if (state_q == S_CMP1) begin
      unit_ref = rd_q.since;
      unit_dur = (rd_q.mode == M_COOLDOWN) ? {1'b0, cooldown_q} : {1'b0, sustain_q};
    end else begin
      unit_ref = rd_q.close;
      unit_dur = {1'b0, merge_q} + DUR_W'(1);
    end
  end

  arsm_elapsed #(
    .TIME_BITS (TIME_BITS)
  ) u_elapsed (
    .now_i     (now_q),
    .ref_i     (unit_ref),
    .dur_i     (unit_dur),
    .elapsed_o (unit_out)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_CMP1) begin
      e1_q <= unit_out;
    end
    if (state_q == S_CMP2) begin
      e2_q <= unit_out;
    end
  end

  // transition decision
  event_code_e dec_code [2];
  mode_e       dec_mode [2];
  mode_e       m;
  logic        proceed;
  logic        sus_nz, cool_nz, merge_nz;

  assign sus_nz   = (sustain_q != '0);
  assign cool_nz  = (cooldown_q != '0);
  assign merge_nz = (merge_q != '0);

  always_comb begin
    dec_entry   = rd_q;
    dec_n       = 2'd0;
    dec_code[0] = EV_TO_NORMAL;
    dec_code[1] = EV_TO_NORMAL;
    dec_mode[0] = M_NORMAL;
    dec_mode[1] = M_NORMAL;
    m           = rd_q.mode;
    proceed     = 1'b1;
    // expired cooldown falls through to normal handling
    if (m == M_COOLDOWN) begin
      if (e1_q) begin
        m               = M_NORMAL;
        dec_entry.mode  = M_NORMAL;
        dec_entry.since = now_q;
        dec_code[0]     = EV_TO_NORMAL;
        dec_mode[0]     = M_NORMAL;
        dec_n           = 2'd1;
      end else begin
        proceed = 1'b0;
      end
    end
    if (proceed && hd_q && (m inside {M_NORMAL, M_PENDING})) begin
      if (!cm_q) begin
        if (m == M_PENDING) begin
          dec_entry.mode        = M_NORMAL;
          dec_entry.since       = now_q;
          dec_code[dec_n[0]]    = EV_TO_NORMAL;
          dec_mode[dec_n[0]]    = M_NORMAL;
          dec_n                 = dec_n + 2'd1;
        end
      end else if (m == M_NORMAL && sus_nz) begin
        dec_entry.mode     = M_PENDING;
        dec_entry.since    = now_q;
        dec_code[dec_n[0]] = EV_PENDING;
        dec_mode[dec_n[0]] = M_PENDING;
        dec_n              = dec_n + 2'd1;
      end else if (m == M_NORMAL || e1_q) begin
        dec_entry.mode     = M_FIRING;
        dec_entry.since    = now_q;
        dec_mode[dec_n[0]] = M_FIRING;
        // refire inside the merge window reopens the last incident
        if (rd_q.has_inc && merge_nz && !e2_q) begin
          dec_entry.has_inc  = 1'b0;
          dec_entry.close    = '0;
          dec_code[dec_n[0]] = EV_FIRE_REOPEN;
        end else begin
          dec_code[dec_n[0]] = EV_FIRE_NEW;
        end
        dec_n = dec_n + 2'd1;
      end
    end else if (proceed && (m inside {M_FIRING, M_RECOVERING})) begin
      if (m == M_FIRING && hd_q && cm_q) begin
        dec_code[dec_n[0]] = EV_HIT;
        dec_mode[dec_n[0]] = M_FIRING;
        dec_n              = dec_n + 2'd1;
      end
      if (hd_q) begin
        if (m == M_RECOVERING && !rm_q) begin
          dec_entry.mode     = M_FIRING;
          dec_entry.since    = now_q;
          dec_code[dec_n[0]] = EV_BACK_FIRING;
          dec_mode[dec_n[0]] = M_FIRING;
          dec_n              = dec_n + 2'd1;
        end else if (rm_q) begin
          if (m == M_FIRING && sus_nz) begin
            dec_entry.mode     = M_RECOVERING;
            dec_entry.since    = now_q;
            dec_code[dec_n[0]] = EV_RECOVERING;
            dec_mode[dec_n[0]] = M_RECOVERING;
            dec_n              = dec_n + 2'd1;
          end else if (m == M_FIRING || e1_q) begin
            dec_entry.has_inc = 1'b1;
            dec_entry.close   = now_q;
            dec_entry.since   = now_q;
            if (cool_nz) begin
              dec_entry.mode     = M_COOLDOWN;
              dec_code[dec_n[0]] = EV_CLOSE_COOLDOWN;
              dec_mode[dec_n[0]] = M_COOLDOWN;
            end else begin
              dec_entry.mode     = M_NORMAL;
              dec_code[dec_n[0]] = EV_CLOSE_NORMAL;
              dec_mode[dec_n[0]] = M_NORMAL;
            end
            dec_n = dec_n + 2'd1;
          end
        end
      end
    end
  end

  // event records
  event_t [1:0] dec_ev;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dec_ev[i].device = dev_q;
      dec_ev[i].code   = dec_code[i];
      dec_ev[i].mode   = dec_mode[i];
      dec_ev[i].peak   = peak_q;
      dec_ev[i].last   = (2'(i) == (dec_n - 2'd1));
    end
  end

  arsm_evq u_evq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (q_load),
    .n_i            (dec_n),
    .ev_i           (dec_ev),
    .empty_o        (q_empty),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_device_o (event_device_o),
    .event_code_o   (event_code_o),
    .new_mode_o     (new_mode_o),
    .event_peak_o   (event_peak_o),
    .last_event_o   (last_event_o)
  );

  `ARSM_ASSERT(a_load_commit, q_load |-> (state_q == S_COMMIT) && q_empty, "events loaded outside commit")
  `ARSM_ASSERT(a_clear_walk, (state_q == S_CLEAR) && !clr_last |=> clr_q == $past(clr_q) + 1'b1, "clearing pass skipped an entry")
  `ARSM_ASSERT(a_cmp_order, state_q == S_CMP2 |=> state_q == S_COMMIT, "commit did not follow second compare")
  `ARSM_ASSERT_RST(a_reset_clear, !rst_ni |=> state_q == S_CLEAR, "reset did not start clearing pass")

endmodule
